[design/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the byte stream bit right shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

  localparam int unsigned CntW   = 7;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Register indexes of the configuration port.
  localparam logic [1:0] RegShiftBits = 2'd0;
  localparam logic [1:0] RegFillOnes  = 2'd1;
  localparam logic [1:0] RegOutLength = 2'd2;

  typedef struct packed {
    logic [7:0]      shift_bits;
    logic            fill_ones;
    logic [CntW-1:0] out_length;
  } bsr_cfg_t;

  // One classified input request, as handed from front to back.
  typedef struct packed {
    logic [7:0]      main_byte;
    logic [7:0]      tail_byte;
    logic [7:0]      fill_byte;
    logic [4:0]      n_fill;
    logic            has_tail;
    logic [CntW-1:0] total;
    logic [CntW-1:0] base;
    logic [CntW-1:0] limit;
    logic            ovf;
  } bsr_job_t;

endpackage

`default_nettype wire

[design/byte_stream_bit_right_shifter_unit.sv]
// ----------------------------------------------------------------------------
// byte_stream_bit_right_shifter_unit
// Shifts a byte packet right by a set number of bits into a fixed-length
// output packet, with one or zero fill and an overflow flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tdata[7:0] source byte, tlast last source byte
//  m_axis    out        tdata[7:0] output byte, tlast last output byte,
//                       tuser overflow flag
//  APB       in/out     shift_bits @0x0, fill_ones @0x4, out_length @0x8
//
//  The back emits one output byte per cycle from its output register unless
//  m_axis_tready holds it. The first byte of a packet adds shift_bits/8 fill
//  bytes, the last one adds the tail and padding bytes up to out_length. A
//  two-entry job queue lets the front keep accepting until it is full while
//  the back is stalled. Reset clears packet state and restores the registers.
`default_nettype none

module byte_stream_bit_right_shifter_unit #(
  parameter int unsigned MAX_OUT_BYTES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // APB configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Source stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tlast,
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] overflow
);
  import bsr_pkg::*;

  bsr_cfg_t   cfg_q;
  bsr_job_t   push_job, head_job;
  logic       push, pop, q_full, q_empty, wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_bits <= 8'h00;
      cfg_q.fill_ones  <= 1'b0;
      cfg_q.out_length <= CntW'(MAX_OUT_BYTES);
    end else if (wr_en) begin
      unique case (reg_idx)
        RegShiftBits: cfg_q.shift_bits <= pwdata[7:0];
        RegFillOnes:  cfg_q.fill_ones  <= pwdata[0];
        RegOutLength: cfg_q.out_length <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegShiftBits: prdata = {24'h0, cfg_q.shift_bits};
      RegFillOnes:  prdata = {31'h0, cfg_q.fill_ones};
      RegOutLength: prdata = {{(32-CntW){1'b0}}, cfg_q.out_length};
      default:      prdata = 32'h0;
    endcase
  end

  bsr_front #(
    .MAX_OUT_BYTES(MAX_OUT_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .q_full_i  (q_full),
    .q_push_o  (push),
    .q_job_o   (push_job)
  );

  bsr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  bsr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_job_i   (head_job),
    .q_pop_o   (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_ovf_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

[design/bsr_front.sv]
// ----------------------------------------------------------------------------
// bsr_front
// Accepts source bytes, tracks packet state and builds one job per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_front #(
  parameter int unsigned MAX_OUT_BYTES = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bsr_pkg::bsr_cfg_t    cfg_i,
  input  wire                  s_valid_i,
  output logic                 s_ready_o,
  input  wire [7:0]            s_data_i,
  input  wire                  s_last_i,
  input  wire                  q_full_i,
  output logic                 q_push_o,
  output bsr_pkg::bsr_job_t    q_job_o
);
  import bsr_pkg::*;

  localparam logic [CntW-1:0] LimMax = CntW'(MAX_OUT_BYTES);

  logic            in_pkt_q, in_pkt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      carry_q, carry_d;

  logic            first;
  logic [2:0]      r;
  logic [7:0]      mask_right, mask_left, fill_byte, carry0, carry_new;
  logic [15:0]     cw_main, cw_tail;
  logic [CntW-1:0] lim, cnt0, avail, want, emit_main;
  logic [4:0]      nf;
  logic            nt, ovf0, drop, accept;

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && !q_full_i;
  assign q_push_o  = accept;

  always_comb begin
    first      = !in_pkt_q;
    r          = cfg_i.shift_bits[2:0];
    mask_right = ~(8'hFF << r);
    mask_left  = 8'hFF >> r;
    fill_byte  = cfg_i.fill_ones ? 8'hFF : 8'h00;

    if (cfg_i.out_length == '0) begin
      lim = CntW'(1);
    end else if (cfg_i.out_length > LimMax) begin
      lim = LimMax;
    end else begin
      lim = cfg_i.out_length;
    end

    cnt0   = first ? '0 : cnt_q;
    ovf0   = first ? 1'b0 : ovf_q;
    carry0 = first ? (cfg_i.fill_ones ? mask_right : 8'h00) : carry_q;

    // The carried low bits land on top of the next byte; for r of zero they
    // shift out of the low byte entirely.
    cw_main   = {8'h00, carry0} << (4'd8 - {1'b0, r});
    carry_new = s_data_i & mask_right;
    cw_tail   = {8'h00, carry_new} << (4'd8 - {1'b0, r});

    nf    = first ? cfg_i.shift_bits[7:3] : 5'd0;
    nt    = s_last_i && (r != 3'd0);
    avail = (cnt0 >= lim) ? '0 : lim - cnt0;
    want  = CntW'(nf) + CntW'(1) + CntW'(nt);
    drop  = want > avail;
    emit_main = drop ? avail : want;

    q_job_o.main_byte = (s_data_i >> r) | cw_main[7:0];
    q_job_o.tail_byte = cw_tail[7:0] | (cfg_i.fill_ones ? mask_left : 8'h00);
    q_job_o.fill_byte = fill_byte;
    q_job_o.n_fill    = nf;
    q_job_o.has_tail  = nt;
    // The last byte of a packet pads up to the output length.
    q_job_o.total     = s_last_i ? avail : emit_main;
    q_job_o.base      = cnt0;
    q_job_o.limit     = lim;
    q_job_o.ovf       = ovf0 | drop;

    if (s_last_i) begin
      in_pkt_d = 1'b0;
      cnt_d    = '0;
      ovf_d    = 1'b0;
      carry_d  = 8'h00;
    end else begin
      in_pkt_d = 1'b1;
      cnt_d    = cnt0 + emit_main;
      ovf_d    = ovf0 | drop;
      carry_d  = carry_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      carry_q  <= 8'h00;
    end else if (accept) begin
      in_pkt_q <= in_pkt_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      carry_q  <= carry_d;
    end
  end

endmodule

`default_nettype wire

[design/bsr_queue.sv]
// ----------------------------------------------------------------------------
// bsr_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  bsr_pkg::bsr_job_t  push_job_i,
  output logic               full_o,
  input  wire                pop_i,
  output logic               empty_o,
  output bsr_pkg::bsr_job_t  head_o
);
  import bsr_pkg::*;

  bsr_job_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   fill_q;

  assign full_o  = fill_q == (QPtrW+1)'(QDepth);
  assign empty_o = fill_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/bsr_back.sv]
// ----------------------------------------------------------------------------
// bsr_back
// Walks through a job one output byte per cycle into the output register, while that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_empty_i,
  input  bsr_pkg::bsr_job_t  q_job_i,
  output logic               q_pop_o,
  output logic               m_valid_o,
  input  wire                m_ready_i,
  output logic [7:0]         m_data_o,
  output logic               m_last_o,
  output logic               m_ovf_o
);
  import bsr_pkg::*;

  logic [CntW-1:0] pos_q, pos_d;
  logic            vld_q, vld_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d, ovf_q, ovf_d;
  logic            load, slot_free, end_of_job;
  logic [CntW-1:0] nf_ext;
  logic [CntW:0]   out_idx;

  assign m_valid_o = vld_q;
  assign m_data_o  = byte_q;
  assign m_last_o  = last_q;
  assign m_ovf_o   = ovf_q;

  always_comb begin
    slot_free  = !vld_q || m_ready_i;
    nf_ext     = CntW'(q_job_i.n_fill);
    end_of_job = pos_q == (q_job_i.total - CntW'(1));
    load       = !q_empty_i && (q_job_i.total != '0) && slot_free;
    // A job with nothing to send is dropped from the queue at once.
    q_pop_o    = !q_empty_i && ((q_job_i.total == '0) || (slot_free && end_of_job));

    if (pos_q < nf_ext) begin
      byte_d = q_job_i.fill_byte;
    end else if (pos_q == nf_ext) begin
      byte_d = q_job_i.main_byte;
    end else if (q_job_i.has_tail && (pos_q == nf_ext + CntW'(1))) begin
      byte_d = q_job_i.tail_byte;
    end else begin
      byte_d = q_job_i.fill_byte;
    end

    out_idx = {1'b0, q_job_i.base} + {1'b0, pos_q} + (CntW+1)'(1);
    last_d  = out_idx == {1'b0, q_job_i.limit};
    ovf_d   = q_job_i.ovf;

    if (load) begin
      vld_d = 1'b1;
    end else if (m_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end

    if (load) begin
      pos_d = end_of_job ? '0 : pos_q + CntW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire
